// ===== design/task_queue_dispatcher_defines.svh =====
// ----------------------------------------------------------------------------
// Task queue dispatcher assertion macros
// Shared property wrappers clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TASK_QUEUE_DISPATCHER_DEFINES_SVH
`define TASK_QUEUE_DISPATCHER_DEFINES_SVH

// Same-cycle implication.
`define TQD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tqd_pkg.sv =====
// ----------------------------------------------------------------------------
// tqd_pkg
// Shared types, codes and defaults of the task queue dispatcher.
// ----------------------------------------------------------------------------
package tqd_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TASK_IDS_DEF    = 256;
    localparam int CNT_W           = 7;
    localparam int CAP_W           = 7;

    localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [3:0] OP_TASK_INIT  = 4'd0;
    localparam logic [3:0] OP_QUEUE_INIT = 4'd1;
    localparam logic [3:0] OP_ENQUEUE    = 4'd2;
    localparam logic [3:0] OP_START      = 4'd3;
    localparam logic [3:0] OP_STOP       = 4'd4;
    localparam logic [3:0] OP_DEQ_ONE    = 4'd5;
    localparam logic [3:0] OP_DEQ_BATCH  = 4'd6;
    localparam logic [3:0] OP_RUN_BEGIN  = 4'd7;
    localparam logic [3:0] OP_RUN_END    = 4'd8;
    localparam logic [3:0] OP_CLAIM      = 4'd9;
    localparam logic [3:0] OP_TERM       = 4'd10;
    localparam logic [3:0] OP_RESET      = 4'd11;
    localparam logic [3:0] OP_QUERY      = 4'd12;

    localparam logic [2:0] QS_INIT     = 3'd0;
    localparam logic [2:0] QS_RUN      = 3'd1;
    localparam logic [2:0] QS_STOPPING = 3'd2;
    localparam logic [2:0] QS_STOP     = 3'd3;
    localparam logic [2:0] QS_DONE     = 3'd4;

    localparam logic [1:0] TS_INIT  = 2'd0;
    localparam logic [1:0] TS_READY = 2'd1;
    localparam logic [1:0] TS_RUN   = 2'd2;
    localparam logic [1:0] TS_DONE  = 2'd3;

    typedef struct packed {
        logic [3:0]       operation;
        logic [7:0]       task_id;
        logic [CAP_W-1:0] batch_limit;
    } in_item_t;

    typedef struct packed {
        logic             ok;
        logic [7:0]       out_task_id;
        logic [2:0]       queue_status;
        logic [CNT_W-1:0] total_tasks;
        logic [CNT_W-1:0] ready_tasks;
        logic [CNT_W-1:0] running_tasks;
        logic [CNT_W-1:0] finished_tasks;
        logic             last;
    } out_item_t;

    typedef struct packed {
        tqd_pkg::in_item_t item;
        logic              id_ok;
    } cmd_t;

endpackage

// ===== design/tqd_front.sv =====
// ----------------------------------------------------------------------------
// tqd_front
// Accepts input items, checks the task id range and holds them in a
// two-entry command queue for the execution side.
// ----------------------------------------------------------------------------
module tqd_front #(
    parameter int TASK_IDS = tqd_pkg::TASK_IDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tqd_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output tqd_pkg::cmd_t     cmd
);

    tqd_pkg::cmd_t ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] n_reg, n_next;
    logic       push, pop;
    tqd_pkg::cmd_t new_cmd;

    assign s_ready   = (n_reg != 2'd2);
    assign cmd_valid = (n_reg != 2'd0);
    assign cmd       = ent_reg[rp_reg];
    assign push      = s_valid & s_ready;
    assign pop       = cmd_pop & cmd_valid;

    always_comb begin
        new_cmd.item  = s_data;
        new_cmd.id_ok = (int'(s_data.task_id) < TASK_IDS);
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        n_next  = n_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            n_reg  <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= new_cmd;
        end
    end

endmodule

// ===== design/tqd_back.sv =====
// ----------------------------------------------------------------------------
// tqd_back
// Executes queued commands: queue state, counters, slot store and task
// state table, slot walks for batches and rearm, and the result register.
// ----------------------------------------------------------------------------
module tqd_back #(
    parameter int QUEUE_DEPTH = tqd_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_IDS    = tqd_pkg::TASK_IDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  tqd_pkg::cmd_t                 cmd,
    input  logic                          cfg_valid,
    input  logic [tqd_pkg::CAP_W-1:0]     cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tqd_pkg::out_item_t            m_data
);

    localparam int IW        = $clog2(QUEUE_DEPTH + 1);
    localparam int SA        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TBL_DEPTH = (TASK_IDS > 256) ? 256 : TASK_IDS;
    localparam int TA        = $clog2(TBL_DEPTH);
    localparam int CAP_INIT  = (QUEUE_DEPTH < 64) ? QUEUE_DEPTH : 64;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OP   = 3'd1;
    localparam logic [2:0] ST_DEQ  = 3'd2;
    localparam logic [2:0] ST_CLM  = 3'd3;
    localparam logic [2:0] ST_RST  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    typedef logic [tqd_pkg::CNT_W-1:0] cnt_t;

    function automatic cnt_t up1(input cnt_t v);
        return (v == tqd_pkg::CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

    function automatic cnt_t dn1(input cnt_t v);
        return (v == cnt_t'(0)) ? v : v - cnt_t'(1);
    endfunction

    // memories
    logic [7:0] slot_mem [QUEUE_DEPTH];
    logic [1:0] tbl_mem  [TBL_DEPTH];
    logic [7:0] slot_rdata_reg;
    logic [1:0] tbl_rdata_reg;
    logic       tbl_vq_reg;
    logic [TBL_DEPTH-1:0] tbl_vld_reg;

    logic          slot_we;
    logic [SA-1:0] slot_wa, slot_ra;
    logic [7:0]    slot_wd;
    logic          tbl_we;
    logic [TA-1:0] tbl_wa, tbl_ra;
    logic [1:0]    tbl_wd;
    logic [1:0]    tstate;

    logic [2:0]    st_reg, st_next;
    logic          ph_reg, ph_next;
    logic [2:0]    q_reg, q_next;
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [IW-1:0] ptr_reg, ptr_next, base_reg, base_next, cnt_reg, cnt_next;
    logic [IW-1:0] capu_reg, capu_next;
    logic [tqd_pkg::CAP_W-1:0] cap_reg, grp_reg, grp_next;
    cnt_t tot_reg, tot_next, rdy_reg, rdy_next, run_reg, run_next, done_reg, done_next;
    logic          ok_reg, ok_next;
    tqd_pkg::cmd_t cmd_reg, cmd_next;
    logic          m_valid_reg, m_valid_next;
    tqd_pkg::out_item_t m_data_reg, m_data_next;

    logic          can_emit, emit, emit_ok, emit_last;
    logic [7:0]    emit_id;
    logic [tqd_pkg::CAP_W-1:0] lim, gran;
    logic [IW-1:0] diff, wlen, ptr_inc;
    logic          sid_ok, gend;
    cnt_t          done_inc;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign can_emit = !m_valid_reg || m_ready;
    assign tstate   = tbl_vq_reg ? tbl_rdata_reg : tqd_pkg::TS_INIT;
    // hold the head read and the table read on the command while it waits
    assign slot_ra  = (st_reg == ST_IDLE || st_reg == ST_OP) ? head_reg[SA-1:0]
                                                              : ptr_reg[SA-1:0];
    assign tbl_ra   = (st_reg == ST_IDLE) ? cmd.item.task_id[TA-1:0]
                                          : cmd_reg.item.task_id[TA-1:0];

    always_comb begin
        lim      = cmd_reg.item.batch_limit;
        gran     = (lim == '0) ? tqd_pkg::CAP_W'(1) : lim;
        diff     = tail_reg - head_reg;
        wlen     = (tqd_pkg::CAP_W'(diff) > lim) ? IW'(lim) : diff;
        ptr_inc  = ptr_reg + IW'(1);
        sid_ok   = (int'(slot_rdata_reg) < TASK_IDS);
        done_inc = up1(done_reg);
        gend     = (tqd_pkg::CAP_W'(grp_reg + tqd_pkg::CAP_W'(1)) == gran)
                   || (ptr_inc == tail_reg);

        st_next   = st_reg;
        ph_next   = ph_reg;
        q_next    = q_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        ptr_next  = ptr_reg;
        base_next = base_reg;
        cnt_next  = cnt_reg;
        grp_next  = grp_reg;
        capu_next = capu_reg;
        tot_next  = tot_reg;
        rdy_next  = rdy_reg;
        run_next  = run_reg;
        done_next = done_reg;
        ok_next   = ok_reg;
        cmd_next  = cmd_reg;
        cmd_pop   = 1'b0;
        slot_we   = 1'b0;
        slot_wa   = tail_reg[SA-1:0];
        slot_wd   = cmd_reg.item.task_id;
        tbl_we    = 1'b0;
        tbl_wa    = cmd_reg.item.task_id[TA-1:0];
        tbl_wd    = tqd_pkg::TS_INIT;
        emit      = 1'b0;
        emit_ok   = 1'b0;
        emit_id   = 8'd0;
        emit_last = 1'b1;

        unique case (st_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    st_next  = ST_OP;
                end
            end
            ST_OP: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    st_next = ST_IDLE;
                    unique case (cmd_reg.item.operation)
                        tqd_pkg::OP_TASK_INIT: begin
                            if (cmd_reg.id_ok) begin
                                tbl_we  = 1'b1;
                                tbl_wd  = tqd_pkg::TS_INIT;
                                emit_ok = 1'b1;
                            end
                        end
                        tqd_pkg::OP_QUEUE_INIT: begin
                            capu_next = (int'(cap_reg) > QUEUE_DEPTH) ?
                                        IW'(QUEUE_DEPTH) : IW'(cap_reg);
                            q_next    = tqd_pkg::QS_INIT;
                            head_next = '0;
                            tail_next = '0;
                            tot_next  = '0;
                            rdy_next  = '0;
                            run_next  = '0;
                            done_next = '0;
                            emit_ok   = 1'b1;
                        end
                        tqd_pkg::OP_ENQUEUE: begin
                            if (cmd_reg.id_ok && tstate == tqd_pkg::TS_INIT
                                && tail_reg < capu_reg) begin
                                tbl_we    = 1'b1;
                                tbl_wd    = tqd_pkg::TS_READY;
                                slot_we   = 1'b1;
                                tail_next = tail_reg + IW'(1);
                                tot_next  = up1(tot_reg);
                                rdy_next  = up1(rdy_reg);
                                if (q_reg == tqd_pkg::QS_DONE) begin
                                    q_next = tqd_pkg::QS_RUN;
                                end
                                emit_ok = 1'b1;
                            end
                        end
                        tqd_pkg::OP_START: begin
                            if (q_reg == tqd_pkg::QS_INIT || q_reg == tqd_pkg::QS_STOP) begin
                                q_next  = tqd_pkg::QS_RUN;
                                emit_ok = 1'b1;
                            end
                        end
                        tqd_pkg::OP_STOP: begin
                            if (q_reg == tqd_pkg::QS_RUN) begin
                                q_next  = (run_reg == '0) ? tqd_pkg::QS_STOP
                                                          : tqd_pkg::QS_STOPPING;
                                emit_ok = 1'b1;
                            end
                        end
                        tqd_pkg::OP_DEQ_ONE: begin
                            if (q_reg == tqd_pkg::QS_RUN && head_reg < tail_reg) begin
                                emit_id   = slot_rdata_reg;
                                head_next = head_reg + IW'(1);
                                emit_ok   = 1'b1;
                            end
                        end
                        tqd_pkg::OP_DEQ_BATCH: begin
                            if (q_reg == tqd_pkg::QS_RUN && head_reg < tail_reg
                                && wlen != '0) begin
                                emit      = 1'b0;
                                ptr_next  = head_reg;
                                cnt_next  = wlen;
                                head_next = head_reg + wlen;
                                ph_next   = 1'b0;
                                st_next   = ST_DEQ;
                            end
                        end
                        tqd_pkg::OP_RUN_BEGIN: begin
                            if (cmd_reg.id_ok && tstate == tqd_pkg::TS_READY
                                && q_reg != tqd_pkg::QS_STOPPING
                                && q_reg != tqd_pkg::QS_STOP) begin
                                tbl_we   = 1'b1;
                                tbl_wd   = tqd_pkg::TS_RUN;
                                rdy_next = dn1(rdy_reg);
                                run_next = up1(run_reg);
                                emit_ok  = 1'b1;
                            end
                        end
                        tqd_pkg::OP_RUN_END: begin
                            if (cmd_reg.id_ok && tstate == tqd_pkg::TS_RUN) begin
                                tbl_we    = 1'b1;
                                tbl_wd    = tqd_pkg::TS_DONE;
                                run_next  = dn1(run_reg);
                                done_next = done_inc;
                                if (q_reg == tqd_pkg::QS_STOPPING && run_next == '0) begin
                                    q_next = tqd_pkg::QS_STOP;
                                end
                                if (tot_reg == done_inc) begin
                                    q_next = tqd_pkg::QS_DONE;
                                end
                                emit_ok = 1'b1;
                            end
                        end
                        tqd_pkg::OP_CLAIM: begin
                            if (q_reg == tqd_pkg::QS_RUN && head_reg < tail_reg) begin
                                emit      = 1'b0;
                                ptr_next  = head_reg;
                                base_next = head_reg;
                                cnt_next  = '0;
                                grp_next  = '0;
                                ph_next   = 1'b0;
                                st_next   = ST_CLM;
                            end else begin
                                emit_ok = (q_reg == tqd_pkg::QS_DONE);
                            end
                        end
                        tqd_pkg::OP_TERM: begin
                            if (q_reg == tqd_pkg::QS_RUN) begin
                                q_next = tqd_pkg::QS_STOP;
                            end
                            emit_ok = 1'b1;
                        end
                        tqd_pkg::OP_RESET: begin
                            if (q_reg == tqd_pkg::QS_DONE || q_reg == tqd_pkg::QS_STOP) begin
                                q_next    = tqd_pkg::QS_INIT;
                                run_next  = '0;
                                tot_next  = cnt_t'(tail_reg);
                                rdy_next  = cnt_t'(tail_reg);
                                done_next = '0;
                                head_next = '0;
                                emit_ok   = 1'b1;
                                if (tail_reg != '0) begin
                                    emit     = 1'b0;
                                    ok_next  = 1'b1;
                                    ptr_next = '0;
                                    ph_next  = 1'b0;
                                    st_next  = ST_RST;
                                end
                            end
                        end
                        tqd_pkg::OP_QUERY: begin
                            emit_ok = 1'b1;
                        end
                        default: begin
                            emit_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_DEQ: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (can_emit) begin
                    emit      = 1'b1;
                    emit_ok   = 1'b1;
                    emit_id   = slot_rdata_reg;
                    emit_last = (cnt_reg == IW'(1));
                    ptr_next  = ptr_inc;
                    cnt_next  = cnt_reg - IW'(1);
                    ph_next   = 1'b0;
                    if (cnt_reg == IW'(1)) begin
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_CLM: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else begin
                    if (sid_ok) begin
                        tbl_we = 1'b1;
                        tbl_wa = slot_rdata_reg[TA-1:0];
                        tbl_wd = tqd_pkg::TS_DONE;
                    end
                    rdy_next  = dn1(rdy_reg);
                    done_next = done_inc;
                    cnt_next  = cnt_reg + IW'(1);
                    ptr_next  = ptr_inc;
                    grp_next  = gend ? '0 : grp_reg + tqd_pkg::CAP_W'(1);
                    if (gend && tot_reg == done_inc) begin
                        q_next = tqd_pkg::QS_DONE;
                    end
                    ph_next = 1'b0;
                    if (q_next != tqd_pkg::QS_RUN || ptr_inc >= tail_reg) begin
                        head_next = ptr_inc;
                        ptr_next  = base_reg;
                        st_next   = ST_DEQ;
                    end
                end
            end
            ST_RST: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else begin
                    if (sid_ok) begin
                        tbl_we = 1'b1;
                        tbl_wa = slot_rdata_reg[TA-1:0];
                        tbl_wd = tqd_pkg::TS_READY;
                    end
                    ptr_next = ptr_inc;
                    ph_next  = 1'b0;
                    if (ptr_inc == tail_reg) begin
                        st_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    emit_ok = ok_reg;
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = m_data_reg;
        if (emit) begin
            m_data_next.ok             = emit_ok;
            m_data_next.out_task_id    = emit_id;
            m_data_next.queue_status   = q_next;
            m_data_next.total_tasks    = tot_next;
            m_data_next.ready_tasks    = rdy_next;
            m_data_next.running_tasks  = run_next;
            m_data_next.finished_tasks = done_next;
            m_data_next.last           = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            ph_reg      <= 1'b0;
            q_reg       <= tqd_pkg::QS_INIT;
            head_reg    <= '0;
            tail_reg    <= '0;
            ptr_reg     <= '0;
            base_reg    <= '0;
            cnt_reg     <= '0;
            grp_reg     <= '0;
            cap_reg     <= tqd_pkg::CAP_RESET;
            capu_reg    <= IW'(CAP_INIT);
            tot_reg     <= '0;
            rdy_reg     <= '0;
            run_reg     <= '0;
            done_reg    <= '0;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            tbl_vld_reg <= '0;
        end else begin
            st_reg      <= st_next;
            ph_reg      <= ph_next;
            q_reg       <= q_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            ptr_reg     <= ptr_next;
            base_reg    <= base_next;
            cnt_reg     <= cnt_next;
            grp_reg     <= grp_next;
            capu_reg    <= capu_next;
            tot_reg     <= tot_next;
            rdy_reg     <= rdy_next;
            run_reg     <= run_next;
            done_reg    <= done_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (tbl_we) begin
                tbl_vld_reg[tbl_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rdata_reg <= slot_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_rdata_reg <= tbl_mem[tbl_ra];
        tbl_vq_reg    <= tbl_vld_reg[tbl_ra];
    end

endmodule

// ===== design/task_queue_dispatcher.sv =====
// ----------------------------------------------------------------------------
// task_queue_dispatcher
// Work queue controller: task state table, slot store, queue state and
// task counters, driven by one operation per input item.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                         Carries
//  -------  ----------------------------  --------------------------------
//  s_       s_valid s_ready s_data        operation, task id, batch limit
//  m_       m_valid m_ready m_data        one result item, last flags end
//  cfg_     cfg_valid cfg_ready cfg_data  queue capacity (adopted on init)
//
//  Walks: a single-result operation executes after it leaves the two-entry
//  command queue. Batch dequeue reads each delivered slot in turn, claim
//  walks its slots twice (a marking walk, then a delivery walk), and queue
//  reset walks every occupied slot; the slot store's single registered read
//  port paces these walks.
//  Reset: aresetn is synchronous; the task table clears at once through
//  per-entry valid bits, so there is no clearing pass.
//  Stalls: the result register lets the front keep filling the command queue
//  while m_ready is low; the executor holds until the result is taken.
// ----------------------------------------------------------------------------
module task_queue_dispatcher #(
    parameter int QUEUE_DEPTH = tqd_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_IDS    = tqd_pkg::TASK_IDS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  tqd_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tqd_pkg::out_item_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tqd_pkg::CAP_W-1:0] cfg_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    tqd_pkg::cmd_t cmd;

    // capacity writes are always taken
    assign cfg_ready = 1'b1;

    // front: accept, range-check the task id, queue the command
    tqd_front #(
        .TASK_IDS(TASK_IDS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop),
        .cmd      (cmd)
    );

    // back: execute, walk slots, drive results
    tqd_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TASK_IDS   (TASK_IDS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop),
        .cmd      (cmd),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== design/tqd_checker.sv =====
// ----------------------------------------------------------------------------
// tqd_checker
// Port-level checks of the task queue dispatcher result channel.
// ----------------------------------------------------------------------------
`include "task_queue_dispatcher_defines.svh"

module tqd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tqd_pkg::out_item_t m_data
);

    `TQD_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `TQD_ASSERT_SAME(a_fail_no_id, m_valid && !m_data.ok, m_data.out_task_id == 8'd0, "refused result carries a task id")
    `TQD_ASSERT_SAME(a_mid_ok, m_valid && !m_data.last, m_data.ok, "non-final batch item not ok")
    `TQD_ASSERT_NEXT(a_batch_state, m_valid && m_ready && !m_data.last, !m_valid || (m_data.queue_status == $past(m_data.queue_status) && m_data.total_tasks == $past(m_data.total_tasks) && m_data.ready_tasks == $past(m_data.ready_tasks) && m_data.finished_tasks == $past(m_data.finished_tasks)), "batch state changed between items")

endmodule

bind task_queue_dispatcher tqd_checker u_tqd_checker (.*);

// ===== tb/task_queue_dispatcher_test.sv =====
// ----------------------------------------------------------------------------
// Task queue dispatcher testbench
// Drives operations through the input channel, predicts every result item
// with a local model of the queue and compares each result field by field.
// ----------------------------------------------------------------------------
module task_queue_dispatcher_test;
    import tqd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int NIDS = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    task_queue_dispatcher uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // ---------------- queue model ----------------
    logic [6:0] cap_reg;
    logic [6:0] cap_live;
    logic [2:0] qstate;
    logic [7:0] slots[DEPTH];
    logic [1:0] tstate[NIDS];
    int unsigned head, tail, n_total, n_ready, n_run, n_done;

    out_item_t expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int rx_stall = 0;         // cycles left in a long receiver stall
    bit rx_hold = 1'b0;       // long receiver hold-off
    bit rx_jitter = 1'b1;     // random stalls on the receiver

    function automatic int unsigned sat_up(int unsigned v, int unsigned d);
        return (v + d > 127) ? 127 : v + d;
    endfunction

    function automatic int unsigned sat_down(int unsigned v, int unsigned d);
        return (v > d) ? v - d : 0;
    endfunction

    function automatic void push_result(bit ok, logic [7:0] tid, bit is_last);
        out_item_t r;
        r.ok = ok;
        r.out_task_id = tid;
        r.queue_status = qstate;
        r.total_tasks = n_total[6:0];
        r.ready_tasks = n_ready[6:0];
        r.running_tasks = n_run[6:0];
        r.finished_tasks = n_done[6:0];
        r.last = is_last;
        expected_results.push_back(r);
    endfunction

    function automatic void model_reset();
        cap_reg = CAP_RESET;
        cap_live = 7'd64;
        qstate = QS_INIT;
        foreach (slots[i]) slots[i] = '0;
        foreach (tstate[i]) tstate[i] = TS_INIT;
        head = 0; tail = 0;
        n_total = 0; n_ready = 0; n_run = 0; n_done = 0;
    endfunction

    // Work out the result items one operation causes and queue them.
    function automatic void predict_operation(in_item_t it);
        logic [7:0] delivered[$];
        bit ok;
        bit is_batch;
        logic [7:0] one_id;
        int unsigned w, g, took;
        logic [7:0] id;
        ok = 1'b0; is_batch = 1'b0; one_id = '0;
        id = it.task_id;
        case (it.operation)
            OP_TASK_INIT: begin
                tstate[id] = TS_INIT; ok = 1'b1;
            end
            OP_QUEUE_INIT: begin
                cap_live = (cap_reg > DEPTH) ? DEPTH : cap_reg;
                qstate = QS_INIT;
                head = 0; tail = 0;
                n_total = 0; n_ready = 0; n_run = 0; n_done = 0;
                ok = 1'b1;
            end
            OP_ENQUEUE: begin
                if (tstate[id] == TS_INIT && tail < cap_live && tail < DEPTH) begin
                    tstate[id] = TS_READY;
                    slots[tail] = id;
                    tail++;
                    n_total = sat_up(n_total, 1);
                    n_ready = sat_up(n_ready, 1);
                    if (qstate == QS_DONE) qstate = QS_RUN;
                    ok = 1'b1;
                end
            end
            OP_START: begin
                if (qstate == QS_INIT || qstate == QS_STOP) begin
                    qstate = QS_RUN; ok = 1'b1;
                end
            end
            OP_STOP: begin
                if (qstate == QS_RUN) begin
                    qstate = (n_run == 0) ? QS_STOP : QS_STOPPING;
                    ok = 1'b1;
                end
            end
            OP_DEQ_ONE: begin
                if (qstate == QS_RUN && head < tail) begin
                    one_id = slots[head]; head++; ok = 1'b1;
                end
            end
            OP_DEQ_BATCH: begin
                is_batch = 1'b1;
                if (qstate == QS_RUN && head < tail) begin
                    w = tail - head;
                    if (w > it.batch_limit) w = it.batch_limit;
                    for (int i = 0; i < w; i++) delivered.push_back(slots[head + i]);
                    head += w;
                end
            end
            OP_RUN_BEGIN: begin
                if (tstate[id] == TS_READY && qstate != QS_STOPPING
                        && qstate != QS_STOP) begin
                    tstate[id] = TS_RUN;
                    n_ready = sat_down(n_ready, 1);
                    n_run = sat_up(n_run, 1);
                    ok = 1'b1;
                end
            end
            OP_RUN_END: begin
                if (tstate[id] == TS_RUN) begin
                    tstate[id] = TS_DONE;
                    n_run = sat_down(n_run, 1);
                    n_done = sat_up(n_done, 1);
                    if (qstate == QS_STOPPING && n_run == 0) qstate = QS_STOP;
                    if (n_total == n_done) qstate = QS_DONE;
                    ok = 1'b1;
                end
            end
            OP_CLAIM: begin
                is_batch = 1'b1;
                g = (it.batch_limit == 0) ? 1 : it.batch_limit;
                while (qstate == QS_RUN && head < tail) begin
                    w = tail - head;
                    if (w > g) w = g;
                    took = 0;
                    for (int i = 0; i < w; i++) begin
                        tstate[slots[head + i]] = TS_DONE;
                        delivered.push_back(slots[head + i]);
                        took++;
                    end
                    head += took;
                    n_ready = sat_down(n_ready, took);
                    n_done = sat_up(n_done, took);
                    if (n_total == n_done) qstate = QS_DONE;
                end
                if (delivered.size() == 0) ok = (qstate == QS_DONE);
            end
            OP_TERM: begin
                if (qstate == QS_RUN) qstate = QS_STOP;
                ok = 1'b1;
            end
            OP_RESET: begin
                if (qstate == QS_DONE || qstate == QS_STOP) begin
                    qstate = QS_INIT;
                    n_run = 0; n_total = tail; n_ready = tail; n_done = 0;
                    head = 0;
                    for (int i = 0; i < tail; i++) tstate[slots[i]] = TS_READY;
                    ok = 1'b1;
                end
            end
            OP_QUERY: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        if (is_batch && delivered.size() > 0) begin
            foreach (delivered[i])
                push_result(1'b1, delivered[i], i == delivered.size() - 1);
        end else begin
            push_result(ok, one_id, 1'b1);
        end
    endfunction

    // ---------------- channel helpers ----------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d want %0d",
            results_seen, what, got, want);
        errors++;
    endtask

    // Drop valid and idle for a while, now and then.
    task automatic random_gap();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Offer one item and hold it until accepted, then predict its results.
    // Valid stays high so a following item goes out back to back; whoever
    // idles afterwards drops it.
    task automatic send_item(logic [3:0] op, logic [7:0] tid, logic [6:0] lim);
        in_item_t it;
        it.operation = op; it.task_id = tid; it.batch_limit = lim;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_operation(it);
        items_sent++;
    endtask

    task automatic send_gapped(logic [3:0] op, logic [7:0] tid, logic [6:0] lim);
        random_gap();
        send_item(op, tid, lim);
    endtask

    // Wait for every expected result, plus the tail latency of no-result work.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [6:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_reg = value;
    endtask

    // ---------------- result checking ----------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result item, task id %0d", m_data.out_task_id);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.ok !== want.ok) report_mismatch("ok", m_data.ok, want.ok);
                if (m_data.out_task_id !== want.out_task_id)
                    report_mismatch("task id", m_data.out_task_id, want.out_task_id);
                if (m_data.queue_status !== want.queue_status)
                    report_mismatch("status", m_data.queue_status, want.queue_status);
                if (m_data.total_tasks !== want.total_tasks)
                    report_mismatch("total", m_data.total_tasks, want.total_tasks);
                if (m_data.ready_tasks !== want.ready_tasks)
                    report_mismatch("ready", m_data.ready_tasks, want.ready_tasks);
                if (m_data.running_tasks !== want.running_tasks)
                    report_mismatch("running", m_data.running_tasks, want.running_tasks);
                if (m_data.finished_tasks !== want.finished_tasks)
                    report_mismatch("finished", m_data.finished_tasks, want.finished_tasks);
                if (m_data.last !== want.last) report_mismatch("last", m_data.last, want.last);
            end
            results_seen++;
        end
    end

    // Receiver: random stalls, long ones now and then, or a full hold-off.
    always @(posedge aclk) begin
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (!rx_jitter) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 31) == 0) begin
            m_ready <= 1'b0;
            rx_stall <= $urandom_range(10, 40);
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog: count cycles with no handshake on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // Fill the queue with fresh ids starting at base.
    task automatic fill_queue(int base, int n);
        for (int i = 0; i < n; i++) begin
            send_gapped(OP_TASK_INIT, 8'(base + i), '0);
            send_gapped(OP_ENQUEUE, 8'(base + i), '0);
        end
    endtask

    task automatic test_directed();
        send_item(OP_QUERY, 8'hFF, 7'h7F);
        send_item(4'd13, 8'h00, 7'd0);          // unknown code
        send_item(4'd15, 8'hFF, 7'h7F);
        send_item(OP_DEQ_BATCH, 8'd0, 7'd5);    // empty batch, queue not running
        send_item(OP_CLAIM, 8'd0, 7'd0);        // empty claim
        send_item(OP_RESET, 8'd0, 7'd0);        // refused from init
        send_item(OP_ENQUEUE, 8'd255, 7'd0);
        send_item(OP_ENQUEUE, 8'd0, 7'd0);
        send_item(OP_ENQUEUE, 8'd0, 7'd0);      // already ready: refused
        send_item(OP_START, 8'd0, 7'd0);
        send_item(OP_RUN_BEGIN, 8'd255, 7'd0);
        send_item(OP_STOP, 8'd0, 7'd0);         // stopping with one running
        send_item(OP_RUN_BEGIN, 8'd0, 7'd0);    // refused while stopping
        send_item(OP_RUN_END, 8'd255, 7'd0);    // stopping to stop
        send_item(OP_RESET, 8'd0, 7'd0);
        send_item(OP_START, 8'd0, 7'd0);
        send_item(OP_CLAIM, 8'd0, 7'd0);        // zero granularity: groups of one
        send_item(OP_CLAIM, 8'd0, 7'd64);       // empty claim on done queue
        send_item(OP_RESET, 8'd0, 7'd0);
        send_item(OP_START, 8'd0, 7'd0);
        send_item(OP_DEQ_BATCH, 8'd0, 7'd0);    // zero limit delivers nothing
        send_item(OP_DEQ_BATCH, 8'd0, 7'h7F);
        send_item(OP_DEQ_ONE, 8'd0, 7'd0);
        send_item(OP_TERM, 8'd0, 7'd0);
        send_item(OP_QUEUE_INIT, 8'd0, 7'd0);
    endtask

    // Capacity extremes: zero, one, above depth (saturates), full depth.
    // Offer two more enqueues than fit so the overflow is refused.
    task automatic test_capacity();
        logic [6:0] caps[4] = '{7'd0, 7'd1, 7'd127, 7'd64};
        int n_fill;
        foreach (caps[c]) begin
            write_capacity(caps[c]);
            n_fill = (caps[c] > 7'd64) ? 66 : int'(caps[c]) + 2;
            send_item(OP_QUEUE_INIT, 8'd0, 7'd0);
            for (int i = 0; i < n_fill; i++) begin
                send_item(OP_TASK_INIT, 8'(i + 100), '0);
                send_item(OP_ENQUEUE, 8'(i + 100), '0);
            end
            send_item(OP_START, 8'd0, 7'd0);
            send_item(OP_DEQ_BATCH, 8'd0, 7'd64);   // largest batch
            send_item(OP_TERM, 8'd0, 7'd0);
            send_item(OP_RESET, 8'd0, 7'd0);
            send_item(OP_START, 8'd0, 7'd0);
            send_item(OP_CLAIM, 8'd0, 7'd64);
        end
    endtask

    // Hold the receiver off while the sender keeps offering items.
    task automatic test_backpressure();
        int held;
        write_capacity(7'd16);
        send_item(OP_QUEUE_INIT, 8'd0, 7'd0);
        rx_hold = 1'b1;
        fork
            begin
                held = 0;
                while (held < 300) begin
                    @(posedge aclk);
                    held++;
                end
                rx_hold = 1'b0;
            end
            begin
                fill_queue(0, 12);
                send_item(OP_START, 8'd0, 7'd0);
                send_item(OP_CLAIM, 8'd0, 7'd3);
                drain();
            end
        join
        // Pause until every result is back, then go on.
        drain();
        send_item(OP_QUERY, 8'd0, 7'd0);
    endtask

    // Well-formed work sequences with random content, plus some noise.
    task automatic test_random();
        int rounds;
        int n;
        logic [7:0] base;
        logic [7:0] running[$];
        rounds = 0;
        while (items_sent < 500) begin
            rx_jitter = (rounds % 5 != 4);
            if (rounds % 6 == 0) write_capacity(7'($urandom_range(1, 20)));
            send_gapped(OP_QUEUE_INIT, 8'd0, 7'd0);
            base = 8'($urandom_range(0, 255));
            n = $urandom_range(1, 10);
            fill_queue(base, n);
            send_gapped(OP_START, 8'd0, 7'd0);
            running.delete();
            for (int k = 0; k < 8; k++) begin
                case ($urandom_range(0, 9))
                    0: send_gapped(OP_DEQ_ONE, 8'd0, 7'd0);
                    1: send_gapped(OP_DEQ_BATCH, 8'd0, 7'($urandom_range(0, 12)));
                    2, 3: begin
                        base = base + 8'($urandom_range(0, n - 1));
                        send_gapped(OP_RUN_BEGIN, base, '0);
                        running.push_back(base);
                    end
                    4, 5: if (running.size() > 0)
                        send_gapped(OP_RUN_END, running.pop_front(), '0);
                    6: send_gapped(OP_CLAIM, 8'd0, 7'($urandom_range(0, 5)));
                    7: send_gapped(OP_STOP, 8'd0, 7'd0);
                    8: send_gapped(4'($urandom_range(0, 15)), 8'($urandom),
                                   7'($urandom));
                    default: send_gapped(OP_QUERY, 8'($urandom), 7'($urandom));
                endcase
            end
            while (running.size() > 0) send_gapped(OP_RUN_END, running.pop_front(), '0);
            send_gapped(OP_CLAIM, 8'd0, 7'($urandom_range(0, 64)));
            send_gapped(OP_TERM, 8'd0, 7'd0);
            send_gapped(OP_RESET, 8'd0, 7'd0);
            send_gapped(OP_START, 8'd0, 7'd0);
            send_gapped(OP_CLAIM, 8'd0, 7'($urandom_range(0, 4)));
            rounds++;
        end
    endtask

    initial begin
        model_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity();
        test_backpressure();
        test_random();
        drain();
        $display("covered %0d items and %0d results: all operations, capacity",
            items_sent, results_seen);
        $display("extremes, batch and claim walks, long receiver hold-off");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/tqd_pkg.sv
design/tqd_front.sv
design/tqd_back.sv
design/task_queue_dispatcher.sv
design/tqd_checker.sv
tb/task_queue_dispatcher_test.sv
